// ===== sv/ihrl_pkg.sv =====
`default_nettype none

package ihrl_pkg;

  // Input commands carried on the slave-side tuser.
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_CHAR   = 2'd1,
    CMD_END    = 2'd2,
    CMD_UNUSED = 2'd3
  } command_t;

  // Parse phases.
  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_START = 4'd1,
    PH_HEAD  = 4'd2,
    PH_DATA  = 4'd3,
    PH_CHECK = 4'd4,
    PH_SKIP  = 4'd5,
    PH_DONE  = 4'd6,
    PH_ERROR = 4'd7
  } phase_t;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_OK       = 3'd1,
    ST_DONE     = 3'd2,
    ST_BADSTART = 3'd3,
    ST_BADHEX   = 3'd4,
    ST_CSUM     = 3'd5,
    ST_EXT      = 3'd6
  } status_t;

  // Record types that are acted upon.
  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_EOF  = 8'h01;
  localparam logic [7:0] REC_EXT  = 8'h02;

  localparam logic [7:0]  CHAR_COLON    = 8'h3A;
  localparam logic [7:0]  CHAR_LF       = 8'h0A;
  localparam logic [15:0] CTRL_ADDR_RST = 16'hE600;
  localparam logic [7:0]  CTRL_HOLD     = 8'h01;
  localparam logic [7:0]  CTRL_RELEASE  = 8'h00;

  // One result item.
  typedef struct packed {
    logic      write_valid;
    logic [15:0] write_addr;
    logic [7:0]  write_data;
    status_t   status;
  } result_t;

  // Decoded hex digit: ok flag and nibble value.
  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] c);
    hex_digit_t d;
    d.ok    = 1'b0;
    d.value = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d.ok    = 1'b1;
      d.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      d.ok    = 1'b1;
      d.value = c[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ihrl_parser.sv =====
`default_nettype none

// Record parse state and the per-character step. The result is combinational
// from the current state and the offered request; state advances on step_en.
module ihrl_parser (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  step_en,
  input  wire [1:0]            command,
  input  wire [7:0]            char_in,
  input  wire [15:0]           ctrl_addr,
  output logic                 res_valid,
  output ihrl_pkg::result_t    res
);

  ihrl_pkg::phase_t phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [7:0]  record_length, record_length_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  byte_index, byte_index_next;

  ihrl_pkg::hex_digit_t digit;
  logic [7:0]  byte_val;
  logic [7:0]  sum_add;
  logic [7:0]  index_inc;
  logic [15:0] data_addr;

  always_comb begin
    digit     = ihrl_pkg::hex_decode(char_in);
    byte_val  = {high_nibble, digit.value};
    sum_add   = running_sum + byte_val;
    index_inc = byte_index + 8'd1;
    data_addr = record_address + {8'h00, byte_index};

    phase_next          = phase;
    digit_count_next    = digit_count;
    record_length_next  = record_length;
    record_address_next = record_address;
    running_sum_next    = running_sum;
    high_nibble_next    = high_nibble;
    byte_index_next     = byte_index;
    res_valid           = 1'b0;
    res                 = '0;

    unique case (ihrl_pkg::command_t'(command))
      ihrl_pkg::CMD_BEGIN: begin
        phase_next          = ihrl_pkg::PH_START;
        digit_count_next    = '0;
        record_length_next  = '0;
        record_address_next = '0;
        running_sum_next    = '0;
        high_nibble_next    = '0;
        byte_index_next     = '0;
        res_valid           = 1'b1;
        res.write_valid     = 1'b1;
        res.write_addr      = ctrl_addr;
        res.write_data      = ihrl_pkg::CTRL_HOLD;
        res.status          = ihrl_pkg::ST_BUSY;
      end
      ihrl_pkg::CMD_CHAR: begin
        case (phase) inside
          ihrl_pkg::PH_START: begin
            if (char_in != ihrl_pkg::CHAR_COLON) begin
              phase_next = ihrl_pkg::PH_ERROR;
              res_valid  = 1'b1;
              res.status = ihrl_pkg::ST_BADSTART;
            end else begin
              phase_next          = ihrl_pkg::PH_HEAD;
              digit_count_next    = '0;
              record_length_next  = '0;
              record_address_next = '0;
              running_sum_next    = '0;
              high_nibble_next    = '0;
              byte_index_next     = '0;
            end
          end
          ihrl_pkg::PH_SKIP: begin
            if (char_in == ihrl_pkg::CHAR_LF) begin
              phase_next = ihrl_pkg::PH_START;
            end
          end
          ihrl_pkg::PH_HEAD, ihrl_pkg::PH_DATA, ihrl_pkg::PH_CHECK: begin
            if (!digit.ok) begin
              phase_next = ihrl_pkg::PH_ERROR;
              res_valid  = 1'b1;
              res.status = ihrl_pkg::ST_BADHEX;
            end else if (!digit_count[0]) begin
              high_nibble_next = digit.value;
              digit_count_next = digit_count + 3'd1;
            end else begin
              running_sum_next = sum_add;
              if (phase == ihrl_pkg::PH_HEAD) begin
                digit_count_next = digit_count + 3'd1;
                case (digit_count[2:1])
                  2'd0: record_length_next = byte_val;
                  2'd1: record_address_next = {byte_val, 8'h00};
                  2'd2: record_address_next = {record_address[15:8], byte_val};
                  default: begin
                    // Fourth header byte is the record type.
                    digit_count_next = '0;
                    if (byte_val == ihrl_pkg::REC_DATA) begin
                      byte_index_next = '0;
                      phase_next = (record_length == 8'd0) ? ihrl_pkg::PH_CHECK
                                                            : ihrl_pkg::PH_DATA;
                    end else if (byte_val == ihrl_pkg::REC_EOF) begin
                      phase_next      = ihrl_pkg::PH_DONE;
                      res_valid       = 1'b1;
                      res.write_valid = 1'b1;
                      res.write_addr  = ctrl_addr;
                      res.write_data  = ihrl_pkg::CTRL_RELEASE;
                      res.status      = ihrl_pkg::ST_DONE;
                    end else if (byte_val == ihrl_pkg::REC_EXT) begin
                      phase_next = ihrl_pkg::PH_ERROR;
                      res_valid  = 1'b1;
                      res.status = ihrl_pkg::ST_EXT;
                    end else begin
                      phase_next = ihrl_pkg::PH_SKIP;
                    end
                  end
                endcase
              end else if (phase == ihrl_pkg::PH_DATA) begin
                digit_count_next = '0;
                byte_index_next  = index_inc;
                if (index_inc == record_length) begin
                  phase_next = ihrl_pkg::PH_CHECK;
                end
                res_valid       = 1'b1;
                res.write_valid = 1'b1;
                res.write_addr  = data_addr;
                res.write_data  = byte_val;
                res.status      = ihrl_pkg::ST_BUSY;
              end else begin
                digit_count_next = '0;
                res_valid        = 1'b1;
                if (sum_add == 8'd0) begin
                  phase_next = ihrl_pkg::PH_SKIP;
                  res.status = ihrl_pkg::ST_OK;
                end else begin
                  phase_next = ihrl_pkg::PH_ERROR;
                  res.status = ihrl_pkg::ST_CSUM;
                end
              end
            end
          end
          default: ;
        endcase
      end
      ihrl_pkg::CMD_END: begin
        if (phase == ihrl_pkg::PH_START || phase == ihrl_pkg::PH_HEAD ||
            phase == ihrl_pkg::PH_DATA || phase == ihrl_pkg::PH_CHECK ||
            phase == ihrl_pkg::PH_SKIP) begin
          phase_next      = ihrl_pkg::PH_DONE;
          res_valid       = 1'b1;
          res.write_valid = 1'b1;
          res.write_addr  = ctrl_addr;
          res.write_data  = ihrl_pkg::CTRL_RELEASE;
          res.status      = ihrl_pkg::ST_DONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ihrl_pkg::PH_IDLE;
      digit_count    <= '0;
      record_length  <= '0;
      record_address <= '0;
      running_sum    <= '0;
      high_nibble    <= '0;
      byte_index     <= '0;
    end else if (step_en) begin
      phase          <= phase_next;
      digit_count    <= digit_count_next;
      record_length  <= record_length_next;
      record_address <= record_address_next;
      running_sum    <= running_sum_next;
      high_nibble    <= high_nibble_next;
      byte_index     <= byte_index_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/ihrl_skid.sv =====
`default_nettype none

// Two-entry output stage: a result register plus a skid register, so that
// in_ready is registered; a push is taken every cycle the skid is empty.
module ihrl_skid (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  ihrl_pkg::result_t    push_data,
  output logic                 in_ready,
  output logic                 out_valid,
  output ihrl_pkg::result_t    out_data,
  input  wire                  out_ready
);

  logic              skid_valid;
  ihrl_pkg::result_t skid_data;
  logic              pop;

  assign pop      = out_valid && out_ready;
  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/intel_hex_record_loader.sv =====
`default_nettype none

// Intel HEX record loader. The block takes an Intel HEX file one ASCII
// character per request on the slave-side stream, with the command (begin,
// character, end of input) on s_tuser, and turns data records into single-byte
// memory write requests on the master-side stream. A begin command writes 1 to
// the control register address to hold the target CPU in reset; a type 1
// record, or end of input before done or an error, writes 0 there to release
// it and reports done. Data bytes are issued before the record checksum is
// known, so a checksum-error status tells the consumer to discard that
// record's bytes. Every input request is handled by a parse step that is a
// small state update in one pass, and a new character is taken on every clock
// while the output stage has room. A result is registered in the output stage
// before it appears on the master side. The output stage holds two results,
// so s_tready falls only once two results are waiting. The control address is
// written through the cfg channel, which is always ready, and should only be
// changed while no request is in flight.
module intel_hex_record_loader (
  input  wire        clk,
  input  wire        rst,
  // Configuration: control_reg_addr.
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire [15:0] cfg_data,
  // Slave side.
  input  wire        s_tvalid,
  output logic       s_tready,
  input  wire [7:0]  s_tdata,   // [7:0] char_in
  input  wire [1:0]  s_tuser,   // [1:0] command
  // Master side.
  output logic       m_tvalid,
  input  wire        m_tready,
  output logic [23:0] m_tdata,  // [15:0] write_addr, [23:16] write_data
  output logic [3:0]  m_tuser   // [0] write_valid, [3:1] status
);

  logic [15:0]       control_reg_addr;
  logic              accept;
  logic              res_valid;
  ihrl_pkg::result_t res;
  ihrl_pkg::result_t out_res;

  // The control address register accepts a write in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      control_reg_addr <= ihrl_pkg::CTRL_ADDR_RST;
    end else if (cfg_valid) begin
      control_reg_addr <= cfg_data;
    end
  end

  assign accept = s_tvalid && s_tready;

  ihrl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step_en   (accept),
    .command   (s_tuser),
    .char_in   (s_tdata),
    .ctrl_addr (control_reg_addr),
    .res_valid (res_valid),
    .res       (res)
  );

  // Requests that cause no result still pass through the parser; only real
  // results enter the output stage.
  ihrl_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_data  (out_res),
    .out_ready (m_tready)
  );

  assign m_tdata = {out_res.write_data, out_res.write_addr};
  assign m_tuser = {out_res.status, out_res.write_valid};

  // The input stalls only when the output stage is full, so a result waits.
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with no result waiting");

  // A begin request always produces the hold write.
  a_begin_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == ihrl_pkg::CMD_BEGIN) |=> m_tvalid)
    else $error("begin request produced no result");

  // Status-only results carry a zero address and data.
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata == 24'h000000))
    else $error("status result carries write payload");

endmodule

`default_nettype wire
